// ===== rtl/fvis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvis_pkg: shared types and constants of the flame valve interlock sequencer
// Field widths, command codes, register indexes, mode flag positions, register
// reset values, the configuration register set and the result item layout.
// ----------------------------------------------------------------------------
package fvis_pkg;

  // default width of the stored deadlines
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // field widths
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned FLAGS_W  = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // period used by a plain valve disable message
  localparam logic [MS_W-1:0] PLAIN_PERIOD = 32'd100;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 4'd0,
    CMD_ENABLE_IGN   = 4'd1,
    CMD_DISABLE_IGN  = 4'd2,
    CMD_IGNITE       = 4'd3,
    CMD_DISABLE_PILOT = 4'd4,
    CMD_ENABLE_POOF  = 4'd5,
    CMD_DISABLE_POOF = 4'd6,
    CMD_POOF         = 4'd7,
    CMD_READ_CHANGED = 4'd8
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IGNITER_CH   = 3'd0,
    REG_PILOT_CH     = 3'd1,
    REG_POOF_CH      = 3'd2,
    REG_PILOT_PRESENT = 3'd3,
    REG_IGNITE_PERIOD = 3'd4,
    REG_PILOT_DELAY  = 3'd5,
    REG_POOF_MAX     = 3'd6,
    REG_MODULE_ADDR  = 3'd7
  } reg_idx_e;

  // mode flag bit positions
  localparam int unsigned FLG_IGN_EN   = 0;
  localparam int unsigned FLG_IGN_ON   = 1;
  localparam int unsigned FLG_PILOT_ON = 2;
  localparam int unsigned FLG_READY    = 3;
  localparam int unsigned FLG_POOF_EN  = 4;
  localparam int unsigned FLG_POOF_ON  = 5;
  localparam int unsigned FLG_CHANGED  = 6;

  // register reset values
  localparam logic [CHAN_W-1:0] RST_IGNITER_CH   = 8'd0;
  localparam logic [CHAN_W-1:0] RST_PILOT_CH     = 8'd1;
  localparam logic [CHAN_W-1:0] RST_POOF_CH      = 8'd2;
  localparam logic              RST_PILOT_PRESENT = 1'b0;
  localparam logic [MS_W-1:0]   RST_IGNITE_PERIOD = 32'd2000;
  localparam logic [MS_W-1:0]   RST_PILOT_DELAY  = 32'd500;
  localparam logic [MS_W-1:0]   RST_POOF_MAX     = 32'd1000;
  localparam logic [ADDR_W-1:0] RST_MODULE_ADDR  = 16'd0;

  // configuration register set
  typedef struct packed {
    logic [CHAN_W-1:0] igniter_channel;
    logic [CHAN_W-1:0] pilot_channel;
    logic [CHAN_W-1:0] poof_channel;
    logic              pilot_present;
    logic [MS_W-1:0]   ignite_period_ms;
    logic [MS_W-1:0]   pilot_lag_ms;
    logic [MS_W-1:0]   poof_max_ms;
    logic [ADDR_W-1:0] module_address;
  } cfg_t;

  // one result item, message or status
  typedef struct packed {
    logic               is_message;
    logic [ADDR_W-1:0]  msg_address;
    logic [CHAN_W-1:0]  msg_channel;
    logic [MS_W-1:0]    msg_period;
    logic               msg_start_on;
    logic               msg_stop_on;
    logic [FLAGS_W-1:0] status_flags;
    logic               changed_seen;
    logic [MS_W-1:0]    ignite_left_ms;
    logic               last_of_run;
  } result_t;

  // results of one command: up to two messages and the status item
  localparam int unsigned RUN_DEPTH = 3;
  localparam int unsigned RUN_IDX_W = 2;

endpackage

// ===== rtl/fvis_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvis_in_if: command channel
// Valid/ready channel carrying one command with its time arguments.
// ----------------------------------------------------------------------------
interface fvis_in_if;
  logic                          valid;
  logic                          ready;
  logic [fvis_pkg::CMD_W-1:0]    cmd;
  logic [fvis_pkg::MS_W-1:0]     now_ms;
  logic [fvis_pkg::MS_W-1:0]     req_period;
  logic [fvis_pkg::MS_W-1:0]     delay_ms;

  modport source (output valid, cmd, now_ms, req_period, delay_ms, input ready);
  modport sink   (input valid, cmd, now_ms, req_period, delay_ms, output ready);
endinterface

// ===== rtl/fvis_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvis_out_if: result channel
// Valid/ready channel carrying valve messages and status items.
// ----------------------------------------------------------------------------
interface fvis_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_message;
  logic [fvis_pkg::ADDR_W-1:0]   msg_address;
  logic [fvis_pkg::CHAN_W-1:0]   msg_channel;
  logic [fvis_pkg::MS_W-1:0]     msg_period;
  logic                          msg_start_on;
  logic                          msg_stop_on;
  logic [fvis_pkg::FLAGS_W-1:0]  status_flags;
  logic                          changed_seen;
  logic [fvis_pkg::MS_W-1:0]     ignite_left_ms;
  logic                          last_of_run;

  modport source (output valid, is_message, msg_address, msg_channel, msg_period,
                  msg_start_on, msg_stop_on, status_flags, changed_seen,
                  ignite_left_ms, last_of_run, input ready);
  modport sink   (input valid, is_message, msg_address, msg_channel, msg_period,
                  msg_start_on, msg_stop_on, status_flags, changed_seen,
                  ignite_left_ms, last_of_run, output ready);
endinterface

// ===== rtl/fvis_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvis_cfg_regs: configuration register file
// Channel numbers, pilot presence, timing limits and bus address,
// written by index, no read-back.
// ----------------------------------------------------------------------------
module fvis_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fvis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fvis_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output fvis_pkg::cfg_t                    cfg
);

  fvis_pkg::cfg_t cfg_r;
  fvis_pkg::cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (fvis_pkg::reg_idx_e'(cfg_index))
        fvis_pkg::REG_IGNITER_CH:    cfg_nxt.igniter_channel  = cfg_wdata[7:0];
        fvis_pkg::REG_PILOT_CH:      cfg_nxt.pilot_channel    = cfg_wdata[7:0];
        fvis_pkg::REG_POOF_CH:       cfg_nxt.poof_channel     = cfg_wdata[7:0];
        fvis_pkg::REG_PILOT_PRESENT: cfg_nxt.pilot_present    = cfg_wdata[0];
        fvis_pkg::REG_IGNITE_PERIOD: cfg_nxt.ignite_period_ms = cfg_wdata[31:0];
        fvis_pkg::REG_PILOT_DELAY:   cfg_nxt.pilot_lag_ms     = cfg_wdata[31:0];
        fvis_pkg::REG_POOF_MAX:      cfg_nxt.poof_max_ms      = cfg_wdata[31:0];
        fvis_pkg::REG_MODULE_ADDR:   cfg_nxt.module_address   = cfg_wdata[15:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.igniter_channel  <= fvis_pkg::RST_IGNITER_CH;
      cfg_r.pilot_channel    <= fvis_pkg::RST_PILOT_CH;
      cfg_r.poof_channel     <= fvis_pkg::RST_POOF_CH;
      cfg_r.pilot_present    <= fvis_pkg::RST_PILOT_PRESENT;
      cfg_r.ignite_period_ms <= fvis_pkg::RST_IGNITE_PERIOD;
      cfg_r.pilot_lag_ms     <= fvis_pkg::RST_PILOT_DELAY;
      cfg_r.poof_max_ms      <= fvis_pkg::RST_POOF_MAX;
      cfg_r.module_address   <= fvis_pkg::RST_MODULE_ADDR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/fvis_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvis_core: interlock state and command decode
// Holds the mode flags and both deadlines, and turns one registered
// command into up to two valve messages plus the status item.
// ----------------------------------------------------------------------------
module fvis_core #(
  parameter int unsigned TIME_WIDTH = fvis_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fvis_pkg::cfg_t                    cfg,
  input  logic                              fire,
  input  logic [fvis_pkg::CMD_W-1:0]        cmd,
  input  logic [fvis_pkg::MS_W-1:0]         now_ms,
  input  logic [fvis_pkg::MS_W-1:0]         req_period,
  input  logic [fvis_pkg::MS_W-1:0]         delay_ms,
  output fvis_pkg::result_t                 run_items [fvis_pkg::RUN_DEPTH],
  output logic [fvis_pkg::RUN_IDX_W-1:0]    run_count
);

  localparam int unsigned EXT_W = TIME_WIDTH + fvis_pkg::MS_W;

  logic [fvis_pkg::FLAGS_W-1:0] flags_r, flags_nxt;
  logic [TIME_WIDTH-1:0]        ign_dl_r, ign_dl_nxt;
  logic [TIME_WIDTH-1:0]        poof_dl_r, poof_dl_nxt;

  logic [EXT_W-1:0]             now_ext;
  logic [TIME_WIDTH-1:0]        now_t;
  logic [EXT_W-1:0]             addend_ext;
  logic [TIME_WIDTH-1:0]        sum_t;
  logic [fvis_pkg::MS_W-1:0]    poof_period;
  logic [fvis_pkg::MS_W-1:0]    ign_period;
  logic [fvis_pkg::MS_W-1:0]    ign_delay;
  logic [fvis_pkg::MS_W-1:0]    addend;
  logic                         is_enable_ign;
  logic [TIME_WIDTH-1:0]        left_t;
  logic [EXT_W-1:0]             left_ext;
  fvis_pkg::result_t            msg0, msg1, status;
  logic [1:0]                   msg_cnt;
  logic                         seen;

  function automatic fvis_pkg::result_t make_msg(
    input logic [fvis_pkg::ADDR_W-1:0] addr,
    input logic [fvis_pkg::CHAN_W-1:0] chan,
    input logic [fvis_pkg::MS_W-1:0]   period,
    input logic                        start_on,
    input logic                        stop_on
  );
    fvis_pkg::result_t m;
    m              = '0;
    m.is_message   = 1'b1;
    m.msg_address  = addr;
    m.msg_channel  = chan;
    m.msg_period   = period;
    m.msg_start_on = start_on;
    m.msg_stop_on  = stop_on;
    return m;
  endfunction

  // time arguments folded into the deadline width
  assign now_ext = {{TIME_WIDTH{1'b0}}, now_ms};
  assign now_t   = now_ext[TIME_WIDTH-1:0];

  // enable igniter takes its timing from the registers, ignite from the command
  assign is_enable_ign = (fvis_pkg::cmd_e'(cmd) == fvis_pkg::CMD_ENABLE_IGN);
  assign ign_period    = is_enable_ign ? cfg.ignite_period_ms : req_period;
  assign ign_delay     = is_enable_ign ? cfg.pilot_lag_ms     : delay_ms;

  // poof period saturates at the configured maximum
  assign poof_period = (req_period > cfg.poof_max_ms) ? cfg.poof_max_ms : req_period;

  // one shared deadline adder
  assign addend     = (fvis_pkg::cmd_e'(cmd) == fvis_pkg::CMD_POOF) ? poof_period
                                                                    : ign_period;
  assign addend_ext = {{TIME_WIDTH{1'b0}}, addend};
  assign sum_t      = now_t + addend_ext[TIME_WIDTH-1:0];

  // command decode
  always_comb begin
    flags_nxt   = flags_r;
    ign_dl_nxt  = ign_dl_r;
    poof_dl_nxt = poof_dl_r;
    msg0        = '0;
    msg1        = '0;
    msg_cnt     = 2'd0;
    seen        = 1'b0;
    unique case (fvis_pkg::cmd_e'(cmd)) inside
      fvis_pkg::CMD_TICK: begin
        if (flags_r[fvis_pkg::FLG_IGN_ON] && (now_t > ign_dl_r)) begin
          flags_nxt[fvis_pkg::FLG_IGN_ON]  = 1'b0;
          flags_nxt[fvis_pkg::FLG_READY]   = 1'b1;
          flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
          ign_dl_nxt                       = '0;
        end
        if (flags_r[fvis_pkg::FLG_POOF_ON] && (now_t > poof_dl_r)) begin
          flags_nxt[fvis_pkg::FLG_POOF_ON] = 1'b0;
          flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
        end
      end
      fvis_pkg::CMD_ENABLE_IGN, fvis_pkg::CMD_IGNITE: begin
        if (is_enable_ign || flags_r[fvis_pkg::FLG_IGN_EN]) begin
          flags_nxt[fvis_pkg::FLG_IGN_ON] = 1'b1;
          ign_dl_nxt = sum_t;
          msg0       = make_msg(cfg.module_address, cfg.igniter_channel, ign_period,
                                1'b1, 1'b0);
          msg_cnt    = 2'd1;
          if (cfg.pilot_present) begin
            flags_nxt[fvis_pkg::FLG_PILOT_ON] = 1'b1;
            msg1    = make_msg(cfg.module_address, cfg.pilot_channel, ign_delay,
                               1'b0, 1'b1);
            msg_cnt = 2'd2;
          end
        end
        if (is_enable_ign) begin
          flags_nxt[fvis_pkg::FLG_IGN_EN]  = 1'b1;
          flags_nxt[fvis_pkg::FLG_READY]   = 1'b0;
          flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
        end
      end
      fvis_pkg::CMD_DISABLE_IGN: begin
        msg0    = make_msg(cfg.module_address, cfg.igniter_channel,
                           fvis_pkg::PLAIN_PERIOD, 1'b0, 1'b0);
        msg_cnt = 2'd1;
        flags_nxt[fvis_pkg::FLG_IGN_EN]  = 1'b0;
        flags_nxt[fvis_pkg::FLG_IGN_ON]  = 1'b0;
        flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
      end
      fvis_pkg::CMD_DISABLE_PILOT: begin
        // pilot-on flag is left alone here
        if (cfg.pilot_present) begin
          flags_nxt[fvis_pkg::FLG_READY]   = 1'b0;
          flags_nxt[fvis_pkg::FLG_POOF_EN] = 1'b0;
          flags_nxt[fvis_pkg::FLG_POOF_ON] = 1'b0;
          flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
          msg0    = make_msg(cfg.module_address, cfg.poof_channel,
                             fvis_pkg::PLAIN_PERIOD, 1'b0, 1'b0);
          msg1    = make_msg(cfg.module_address, cfg.pilot_channel,
                             fvis_pkg::PLAIN_PERIOD, 1'b0, 1'b0);
          msg_cnt = 2'd2;
        end
      end
      fvis_pkg::CMD_ENABLE_POOF: begin
        flags_nxt[fvis_pkg::FLG_POOF_EN] = 1'b1;
        flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
      end
      fvis_pkg::CMD_DISABLE_POOF: begin
        flags_nxt[fvis_pkg::FLG_POOF_EN] = 1'b0;
        flags_nxt[fvis_pkg::FLG_POOF_ON] = 1'b0;
        flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
        msg0    = make_msg(cfg.module_address, cfg.poof_channel,
                           fvis_pkg::PLAIN_PERIOD, 1'b0, 1'b0);
        msg_cnt = 2'd1;
      end
      fvis_pkg::CMD_POOF: begin
        if (flags_r[fvis_pkg::FLG_READY] && flags_r[fvis_pkg::FLG_POOF_EN]) begin
          if (!flags_r[fvis_pkg::FLG_POOF_ON]) begin
            flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b1;
          end
          flags_nxt[fvis_pkg::FLG_POOF_ON] = 1'b1;
          poof_dl_nxt = sum_t;
          msg0        = make_msg(cfg.module_address, cfg.poof_channel, poof_period,
                                 1'b1, 1'b0);
          msg_cnt     = 2'd1;
        end
      end
      fvis_pkg::CMD_READ_CHANGED: begin
        seen                             = flags_r[fvis_pkg::FLG_CHANGED];
        flags_nxt[fvis_pkg::FLG_CHANGED] = 1'b0;
      end
      default: begin
        flags_nxt = flags_r;
      end
    endcase
  end

  // time left on the igniter, zero when no deadline is pending
  assign left_t   = (ign_dl_nxt != '0) ? (ign_dl_nxt - now_t) : '0;
  assign left_ext = {{fvis_pkg::MS_W{1'b0}}, left_t};

  // status item closing the run
  always_comb begin
    status                = '0;
    status.status_flags   = flags_nxt;
    status.changed_seen   = seen;
    status.ignite_left_ms = left_ext[fvis_pkg::MS_W-1:0];
    status.last_of_run    = 1'b1;
  end

  // pack messages first, status last
  always_comb begin
    run_items[0] = status;
    run_items[1] = status;
    run_items[2] = status;
    case (msg_cnt)
      2'd1: begin
        run_items[0] = msg0;
      end
      2'd2: begin
        run_items[0] = msg0;
        run_items[1] = msg1;
      end
      default: begin
        run_items[0] = status;
      end
    endcase
  end

  assign run_count = msg_cnt + 2'd1;

  // interlock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      ign_dl_r  <= '0;
      poof_dl_r <= '0;
    end else if (fire) begin
      flags_r   <= flags_nxt;
      ign_dl_r  <= ign_dl_nxt;
      poof_dl_r <= poof_dl_nxt;
    end
  end

endmodule

// ===== rtl/fvis_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvis_out_buf: result run buffer
// Holds the results of one command and sends them one per transaction,
// freeing itself in the cycle the last one is taken.
// ----------------------------------------------------------------------------
module fvis_out_buf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  fvis_pkg::result_t                 run_items [fvis_pkg::RUN_DEPTH],
  input  logic [fvis_pkg::RUN_IDX_W-1:0]    run_count,
  output logic                              free,
  fvis_out_if.source                        out_ch
);

  fvis_pkg::result_t                 items_r [fvis_pkg::RUN_DEPTH];
  logic [fvis_pkg::RUN_IDX_W-1:0]    cnt_r;
  logic [fvis_pkg::RUN_IDX_W-1:0]    idx_r, idx_nxt;
  logic                              valid_r, valid_nxt;
  logic                              take;
  logic                              at_last;
  fvis_pkg::result_t                 cur;

  assign take    = valid_r && out_ch.ready;
  assign at_last = (idx_r == (cnt_r - 2'd1));
  assign free    = !valid_r || (take && at_last);

  // read pointer and occupancy
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = '0;
      valid_nxt = 1'b1;
    end else if (take) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (load) begin
      items_r <= run_items;
      cnt_r   <= run_count;
    end
  end

  // current item onto the channel
  always_comb begin
    case (idx_r)
      2'd1:    cur = items_r[1];
      2'd2:    cur = items_r[2];
      default: cur = items_r[0];
    endcase
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.is_message     = cur.is_message;
  assign out_ch.msg_address    = cur.msg_address;
  assign out_ch.msg_channel    = cur.msg_channel;
  assign out_ch.msg_period     = cur.msg_period;
  assign out_ch.msg_start_on   = cur.msg_start_on;
  assign out_ch.msg_stop_on    = cur.msg_stop_on;
  assign out_ch.status_flags   = cur.status_flags;
  assign out_ch.changed_seen   = cur.changed_seen;
  assign out_ch.ignite_left_ms = cur.ignite_left_ms;
  assign out_ch.last_of_run    = cur.last_of_run;

endmodule

// ===== rtl/flame_valve_interlock_sequencer.sv =====
`timescale 1ns / 1ps
// the first result of a command is offered once the command register and then the
//   result run buffer have taken it; a busy buffer holds it in the command register
// the result port sends one item per cycle while ready is held, up to two messages + status
// a new command is taken while the previous run is still being sent
// reset: synchronous, active low; flags and deadlines cleared, registers to defaults
// ----------------------------------------------------------------------------
// flame_valve_interlock_sequencer: flame effect safety interlock
// Command register, interlock state and decode, and a result run buffer
// that sends valve messages followed by one status item per command.
// ----------------------------------------------------------------------------
module flame_valve_interlock_sequencer #(
  parameter int unsigned TIME_WIDTH = fvis_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fvis_in_if.sink                           in_ch,
  fvis_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [fvis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fvis_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  fvis_pkg::cfg_t                    cfg;
  logic                              in_valid_r;
  logic [fvis_pkg::CMD_W-1:0]        cmd_r;
  logic [fvis_pkg::MS_W-1:0]         now_r;
  logic [fvis_pkg::MS_W-1:0]         period_r;
  logic [fvis_pkg::MS_W-1:0]         delay_r;
  logic                              buf_free;
  logic                              load;
  logic                              in_take;
  fvis_pkg::result_t                 run_items [fvis_pkg::RUN_DEPTH];
  logic [fvis_pkg::RUN_IDX_W-1:0]    run_count;

  fvis_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // command register, refilled in the cycle its command moves on
  assign load        = in_valid_r && buf_free;
  assign in_ch.ready = !in_valid_r || load;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r    <= in_ch.cmd;
      now_r    <= in_ch.now_ms;
      period_r <= in_ch.req_period;
      delay_r  <= in_ch.delay_ms;
    end
  end

  fvis_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fire       (load),
    .cmd        (cmd_r),
    .now_ms     (now_r),
    .req_period (period_r),
    .delay_ms   (delay_r),
    .run_items  (run_items),
    .run_count  (run_count)
  );

  fvis_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .run_items (run_items),
    .run_count (run_count),
    .free      (buf_free),
    .out_ch    (out_ch)
  );

endmodule
